// ===== rtl/undirected_cycle_detect_unit_macros.svh =====
// ----------------------------------------------------------------------------
// undirected cycle detect assertion macros
// shared property shorthands for the cycle detect rtl
// ----------------------------------------------------------------------------
`ifndef UNDIRECTED_CYCLE_DETECT_UNIT_MACROS_SVH
`define UNDIRECTED_CYCLE_DETECT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UCD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UCD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// sizes, register codes and transaction types for the cycle detect unit
// ----------------------------------------------------------------------------
package ucd_pkg;

   localparam int MAX_NODES  = 256;
   localparam int MAX_EDGES  = 256;
   localparam int NODE_W     = 8;
   localparam int SLOTS      = 2 * MAX_EDGES;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int ROOT_W     = $clog2(MAX_NODES + 1);

   // configuration port
   localparam int CFG_W      = 9;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;
   localparam int REG_IDX_W  = ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = '0;
   localparam logic [CFG_W-1:0]     NODE_COUNT_RESET = CFG_W'(256);

   typedef struct packed {
      logic              edge_valid;
      logic [NODE_W-1:0] edge_from;
      logic [NODE_W-1:0] edge_to;
      logic              last_edge;
   } req_type;

   typedef struct packed {
      logic cycle_found;
      logic overflow;
   } rsp_type;

endpackage

// ===== rtl/ucd_ram.sv =====
// ----------------------------------------------------------------------------
// ucd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ucd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/undirected_cycle_detect_unit.sv =====
// ----------------------------------------------------------------------------
// undirected_cycle_detect_unit
// loads an undirected multigraph edge by edge into linked adjacency rams and
// runs a stack based depth-first walk to report whether it holds a cycle
// ----------------------------------------------------------------------------
//  channel   ports                          direction  moves
//  request   req_valid req_ready req_data   in         one edge or end marker
//  response  rsp_valid rsp_ready rsp_data   out        cycle_found, overflow
//  config    psel penable pwrite paddr ...  in/out     node_count register
//
//  a request that stores an edge passes S_LINK_A, S_LINK_B and S_LINK_C, any other non-last one
//  stays in S_IDLE; a last request then walks: S_ROOT checks each root and then finishes the
//  roots, S_STEP and S_FETCH follow each adjacency entry, S_HEAD enters a node, S_STEP and S_POP
//  pop a frame, and S_OUT posts the result;
//  the single read port of each adjacency ram and its registered read set these states;
//  reset is synchronous and needs no clearing pass; node_count resets to 256
//  req_ready is low from a transaction that stores an edge or ends a graph
//  until the unit is idle again;
//  the result waits in the output register, and a walk that ends while an
//  older result is still untaken holds until rsp_ready
// ----------------------------------------------------------------------------
`include "undirected_cycle_detect_unit_macros.svh"

module undirected_cycle_detect_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ucd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ucd_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ucd_pkg::ADDR_W-1:0]     paddr,
   input  logic [ucd_pkg::DATA_W-1:0]     pwdata,
   output logic [ucd_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);

   localparam int NODE_W = ucd_pkg::NODE_W;
   localparam int SLOT_W = ucd_pkg::SLOT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_LINK_A, S_LINK_B, S_LINK_C, S_ROOT,
      S_HEAD, S_STEP, S_FETCH, S_POP, S_OUT
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent;
      logic              has_parent;
      logic [SLOT_W-1:0] cursor;
      logic              cursor_valid;
   } frame_type;

   localparam int FRAME_W = $bits(frame_type);

   state_type                        state_ff, state_in;
   ucd_pkg::req_type                 item_ff, item_in;
   logic [ucd_pkg::EDGE_CNT_W-1:0]   edge_total_ff, edge_total_in;
   logic                             overflow_ff, overflow_in;
   logic [ucd_pkg::MAX_NODES-1:0]    head_vld_ff, head_vld_in;
   logic [ucd_pkg::MAX_NODES-1:0]    visited_ff, visited_in;
   logic [ucd_pkg::CFG_W-1:0]        node_count_ff, node_count_in;
   logic [ucd_pkg::ROOT_W-1:0]       root_ff, root_in;
   frame_type                        top_ff, top_in;
   logic [NODE_W-1:0]                sp_ff, sp_in;
   logic                             cycle_ff, cycle_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ucd_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   // ram ports
   logic                             head_we, head_re;
   logic [NODE_W-1:0]                head_waddr, head_raddr;
   logic [SLOT_W-1:0]                head_wdata, head_rdata;
   logic                             link_we, link_re;
   logic [SLOT_W-1:0]                link_waddr, link_raddr;
   logic [SLOT_W:0]                  nxt_wdata, nxt_rdata;
   logic [NODE_W-1:0]                tgt_wdata, tgt_rdata;
   logic                             stk_we, stk_re;
   logic [NODE_W-1:0]                stk_waddr, stk_raddr;
   frame_type                        stk_wdata, stk_rdata;

   logic                             start_walk;
   logic                             csr_write;
   logic [ucd_pkg::ROOT_W-1:0]       root_limit;
   logic [SLOT_W-1:0]                slot_a;
   logic                             req_in_range;
   logic                             nb_in_range;
   frame_type                        upd_frame;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   assign prdata = (paddr[ucd_pkg::ADDR_W-1:2] == ucd_pkg::REG_NODE_COUNT) ?
                   ucd_pkg::DATA_W'(node_count_ff) : '0;

   assign root_limit = (node_count_ff > ucd_pkg::CFG_W'(ucd_pkg::MAX_NODES)) ?
                       ucd_pkg::ROOT_W'(ucd_pkg::MAX_NODES) :
                       ucd_pkg::ROOT_W'(node_count_ff);

   assign slot_a = {edge_total_ff[SLOT_W-2:0], 1'b0};

   assign req_in_range = (int'(req_data.edge_from) < ucd_pkg::MAX_NODES) &&
                         (int'(req_data.edge_to) < ucd_pkg::MAX_NODES);
   assign nb_in_range  = (int'(tgt_rdata) < ucd_pkg::MAX_NODES);

   // top frame after following one adjacency entry
   always_comb begin
      upd_frame              = top_ff;
      upd_frame.cursor       = nxt_rdata[SLOT_W-1:0];
      upd_frame.cursor_valid = nxt_rdata[SLOT_W];
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      head_vld_in   = head_vld_ff;
      visited_in    = visited_ff;
      node_count_in = node_count_ff;
      root_in       = root_ff;
      top_in        = top_ff;
      sp_in         = sp_ff;
      cycle_in      = cycle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      start_walk    = 1'b0;

      head_we    = 1'b0;
      head_waddr = '0;
      head_wdata = '0;
      head_re    = 1'b0;
      head_raddr = '0;
      link_we    = 1'b0;
      link_waddr = '0;
      nxt_wdata  = '0;
      tgt_wdata  = '0;
      link_re    = 1'b0;
      link_raddr = '0;
      stk_we     = 1'b0;
      stk_waddr  = '0;
      stk_wdata  = '0;
      stk_re     = 1'b0;
      stk_raddr  = '0;

      if (csr_write && (paddr[ucd_pkg::ADDR_W-1:2] == ucd_pkg::REG_NODE_COUNT)) begin
         node_count_in = pwdata[ucd_pkg::CFG_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.edge_valid && req_in_range) begin
                  if (edge_total_ff == ucd_pkg::EDGE_CNT_W'(ucd_pkg::MAX_EDGES)) begin
                     overflow_in = 1'b1;
                     start_walk  = req_data.last_edge;
                  end else begin
                     head_re    = 1'b1;
                     head_raddr = req_data.edge_from;
                     state_in   = S_LINK_A;
                  end
               end else begin
                  start_walk = req_data.last_edge;
               end
            end
         end
         S_LINK_A: begin
            link_we     = 1'b1;
            link_waddr  = slot_a;
            nxt_wdata   = {head_vld_ff[item_ff.edge_from], head_rdata};
            tgt_wdata   = item_ff.edge_to;
            head_we     = 1'b1;
            head_waddr  = item_ff.edge_from;
            head_wdata  = slot_a;
            head_vld_in[item_ff.edge_from] = 1'b1;
            state_in    = S_LINK_B;
         end
         S_LINK_B: begin
            // reread so a self-loop sees the head just written
            head_re    = 1'b1;
            head_raddr = item_ff.edge_to;
            state_in   = S_LINK_C;
         end
         S_LINK_C: begin
            link_we     = 1'b1;
            link_waddr  = slot_a | SLOT_W'(1);
            nxt_wdata   = {head_vld_ff[item_ff.edge_to], head_rdata};
            tgt_wdata   = item_ff.edge_from;
            head_we     = 1'b1;
            head_waddr  = item_ff.edge_to;
            head_wdata  = slot_a | SLOT_W'(1);
            head_vld_in[item_ff.edge_to] = 1'b1;
            edge_total_in = edge_total_ff + 1'b1;
            state_in      = S_IDLE;
            start_walk    = item_ff.last_edge;
         end
         S_ROOT: begin
            if (root_ff >= root_limit) begin
               state_in = S_OUT;
            end else if (visited_ff[root_ff[NODE_W-1:0]]) begin
               root_in = root_ff + 1'b1;
            end else begin
               visited_in[root_ff[NODE_W-1:0]] = 1'b1;
               top_in.node       = root_ff[NODE_W-1:0];
               top_in.parent     = '0;
               top_in.has_parent = 1'b0;
               head_re    = 1'b1;
               head_raddr = root_ff[NODE_W-1:0];
               sp_in      = '0;
               root_in    = root_ff + 1'b1;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            top_in.cursor       = head_rdata;
            top_in.cursor_valid = head_vld_ff[top_ff.node];
            state_in            = S_STEP;
         end
         S_STEP: begin
            if (top_ff.cursor_valid) begin
               link_re    = 1'b1;
               link_raddr = top_ff.cursor;
               state_in   = S_FETCH;
            end else if (sp_ff == '0) begin
               state_in = S_ROOT;
            end else begin
               stk_re    = 1'b1;
               stk_raddr = sp_ff - 1'b1;
               sp_in     = sp_ff - 1'b1;
               state_in  = S_POP;
            end
         end
         S_FETCH: begin
            top_in   = upd_frame;
            state_in = S_STEP;
            if (nb_in_range) begin
               if (!visited_ff[tgt_rdata]) begin
                  // park the current frame below and descend
                  stk_we    = 1'b1;
                  stk_waddr = sp_ff;
                  stk_wdata = upd_frame;
                  sp_in     = sp_ff + 1'b1;
                  visited_in[tgt_rdata] = 1'b1;
                  top_in.node       = tgt_rdata;
                  top_in.parent     = top_ff.node;
                  top_in.has_parent = 1'b1;
                  head_re    = 1'b1;
                  head_raddr = tgt_rdata;
                  state_in   = S_HEAD;
               end else if (!top_ff.has_parent || (tgt_rdata != top_ff.parent)) begin
                  cycle_in = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_POP: begin
            top_in   = stk_rdata;
            state_in = S_STEP;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.cycle_found = cycle_ff;
               rsp_data_in.overflow    = overflow_ff;
               head_vld_in             = '0;
               edge_total_in           = '0;
               overflow_in             = 1'b0;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (start_walk) begin
         visited_in = '0;
         root_in    = '0;
         cycle_in   = 1'b0;
         state_in   = S_ROOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         head_vld_ff   <= '0;
         visited_ff    <= '0;
         node_count_ff <= ucd_pkg::NODE_COUNT_RESET;
         sp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         head_vld_ff   <= head_vld_in;
         visited_ff    <= visited_in;
         node_count_ff <= node_count_in;
         sp_ff         <= sp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff     <= item_in;
      root_ff     <= root_in;
      top_ff      <= top_in;
      cycle_ff    <= cycle_in;
      rsp_data_ff <= rsp_data_in;
   end

   // per node list heads
   ucd_ram #(.WIDTH(SLOT_W), .DEPTH(ucd_pkg::MAX_NODES)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (head_re),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   // link to the next entry with its valid bit on top
   ucd_ram #(.WIDTH(SLOT_W + 1), .DEPTH(ucd_pkg::SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (nxt_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (nxt_rdata)
   );

   ucd_ram #(.WIDTH(NODE_W), .DEPTH(ucd_pkg::SLOTS)) u_target_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (tgt_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (tgt_rdata)
   );

   // frames below the top of the walk
   ucd_ram #(.WIDTH(FRAME_W), .DEPTH(ucd_pkg::MAX_NODES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   `UCD_ASSERT_IMP(a_link_has_room, clock, reset, state_ff == S_LINK_A,
      edge_total_ff < ucd_pkg::EDGE_CNT_W'(ucd_pkg::MAX_EDGES), "edge linked into a full store")
   `UCD_ASSERT_IMP(a_top_visited, clock, reset, state_ff == S_HEAD,
      visited_ff[top_ff.node], "walk entered a node not marked visited")
   `UCD_ASSERT_IMP(a_pop_nonempty, clock, reset, state_ff == S_POP,
      $past(sp_ff) != '0, "stack popped while empty")
   `UCD_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_OUT, "response raised outside result posting")

endmodule

// ===== sim/tb_undirected_cycle_detect_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_undirected_cycle_detect_unit
// loads graphs edge by edge and checks each cycle and overflow verdict against
// a depth-first walk kept in the bench or a verdict given in the plan, with
// random idling on both channels and node_count changes between graphs
// ----------------------------------------------------------------------------
module tb_undirected_cycle_detect_unit;

   localparam int MAX_NODES = ucd_pkg::MAX_NODES;
   localparam int MAX_EDGES = ucd_pkg::MAX_EDGES;
   localparam int NODE_W    = ucd_pkg::NODE_W;
   localparam int SLOT_W    = ucd_pkg::SLOT_W;
   localparam int SLOTS     = ucd_pkg::SLOTS;
   localparam int CFG_W     = ucd_pkg::CFG_W;
   localparam int ADDR_W    = ucd_pkg::ADDR_W;
   localparam int DATA_W    = ucd_pkg::DATA_W;
   localparam int REG_IDX_W = ucd_pkg::REG_IDX_W;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int TAIL_CYCLES    = 60;
   localparam int RANDOM_TARGET  = 720;
   localparam int CALM_FROM      = 620;
   localparam int CROWDED_AT     = 250;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED    = REG_IDX_W'(1);
   localparam logic [ADDR_W-1:0]    NODE_COUNT_ADDR = {ucd_pkg::REG_NODE_COUNT, 2'b00};
   localparam logic [ADDR_W-1:0]    UNMAPPED_ADDR   = {REG_UNMAPPED, 2'b00};

   typedef enum logic {ROW_EDGE, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {
      SHAPE_TREE, SHAPE_LOOPED_TREE, SHAPE_SCATTER, SHAPE_EMPTY
   } shape_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [CFG_W-1:0]  value;
      ucd_pkg::req_type  item;
      logic              typed;
      ucd_pkg::rsp_type  verdict;
   } plan_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ucd_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ucd_pkg::rsp_type  rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   undirected_cycle_detect_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // graph copy held by the bench
   logic [SLOT_W-1:0] list_head [MAX_NODES];
   bit                head_used [MAX_NODES];
   logic [SLOT_W-1:0] slot_next [SLOTS];
   bit                next_used [SLOTS];
   logic [NODE_W-1:0] slot_peer [SLOTS];
   bit                node_seen [MAX_NODES];
   int                frame_node [MAX_NODES];
   int                frame_from [MAX_NODES];
   bit                frame_has_from [MAX_NODES];
   logic [SLOT_W-1:0] frame_cursor [MAX_NODES];
   bit                frame_live [MAX_NODES];
   int                frame_depth;
   int                edges_held;
   bit                edges_lost;
   logic [CFG_W-1:0]  root_count;

   ucd_pkg::rsp_type  pending_verdicts [$];
   ucd_pkg::req_type  graph_items [$];
   plan_row_type      plan [$];

   int items_sent        = 0;
   int graphs_sent       = 0;
   int verdicts_checked  = 0;
   int cycles_reported   = 0;
   int overflows_seen    = 0;
   int mismatches        = 0;
   int idle_cycles       = 0;
   int stall_left        = 0;
   bit calm              = 1'b0;

   function automatic void forget_graph();
      for (int n = 0; n < MAX_NODES; n++) head_used[n] = 1'b0;
      for (int s = 0; s < SLOTS; s++) next_used[s] = 1'b0;
      edges_held = 0;
      edges_lost = 1'b0;
   endfunction

   function automatic void attach_slot(int slot, int from, int to);
      slot_peer[slot] = NODE_W'(to);
      slot_next[slot] = list_head[from];
      next_used[slot] = head_used[from];
      list_head[from] = SLOT_W'(slot);
      head_used[from] = 1'b1;
   endfunction

   function automatic void enter_node(int node, int from, bit has_from);
      if (frame_depth < MAX_NODES) begin
         node_seen[node]             = 1'b1;
         frame_node[frame_depth]     = node;
         frame_from[frame_depth]     = from;
         frame_has_from[frame_depth] = has_from;
         frame_cursor[frame_depth]   = list_head[node];
         frame_live[frame_depth]     = head_used[node];
         frame_depth++;
      end
   endfunction

   // explicit-stack dfs; a seen neighbour other than the one we came from closes a loop
   function automatic bit component_has_cycle(int root);
      int top;
      int slot;
      int peer;
      frame_depth = 0;
      enter_node(root, 0, 1'b0);
      while (frame_depth > 0) begin
         top = frame_depth - 1;
         if (!frame_live[top]) begin
            frame_depth--;
         end else begin
            slot              = frame_cursor[top];
            peer              = slot_peer[slot];
            frame_cursor[top] = slot_next[slot];
            frame_live[top]   = next_used[slot];
            if (!node_seen[peer]) begin
               enter_node(peer, frame_node[top], 1'b1);
            end else if (!frame_has_from[top] || peer != frame_from[top]) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit predict_verdict(ucd_pkg::req_type it,
                                          output ucd_pkg::rsp_type verdict);
      int roots;
      bit found;
      verdict = '0;
      if (it.edge_valid) begin
         if (edges_held >= MAX_EDGES) begin
            edges_lost = 1'b1;
         end else begin
            attach_slot(2 * edges_held, it.edge_from, it.edge_to);
            attach_slot(2 * edges_held + 1, it.edge_to, it.edge_from);
            edges_held++;
         end
      end
      if (!it.last_edge) return 1'b0;
      for (int n = 0; n < MAX_NODES; n++) node_seen[n] = 1'b0;
      roots = (root_count > MAX_NODES) ? MAX_NODES : root_count;
      found = 1'b0;
      for (int r = 0; r < roots && !found; r++) begin
         if (!node_seen[r]) found = component_has_cycle(r);
      end
      verdict.cycle_found = found;
      verdict.overflow    = edges_lost;
      forget_graph();
      return 1'b1;
   endfunction

   function automatic plan_row_type mk_edge(logic v, int a, int b, logic last, logic typed,
                                            logic cyc, logic ovf);
      plan_row_type row;
      row                 = '0;
      row.kind            = ROW_EDGE;
      row.item.edge_valid = v;
      row.item.edge_from  = NODE_W'(a);
      row.item.edge_to    = NODE_W'(b);
      row.item.last_edge  = last;
      row.typed           = typed;
      row.verdict         = '{cycle_found: cyc, overflow: ovf};
      return row;
   endfunction

   function automatic plan_row_type mk_csr(logic [ADDR_W-1:0] addr, int value);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.addr  = addr;
      row.value = CFG_W'(value);
      return row;
   endfunction

   function automatic void add_row(plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic void add_item(ucd_pkg::req_type it);
      graph_items.insert(graph_items.size(), it);
   endfunction

   function automatic ucd_pkg::req_type edge_item(int a, int b);
      ucd_pkg::req_type it;
      it.edge_valid = 1'b1;
      it.last_edge  = 1'b0;
      if ($urandom_range(0, 1)) begin
         it.edge_from = NODE_W'(a);
         it.edge_to   = NODE_W'(b);
      end else begin
         it.edge_from = NODE_W'(b);
         it.edge_to   = NODE_W'(a);
      end
      return it;
   endfunction

   function automatic ucd_pkg::req_type noise_item();
      ucd_pkg::req_type it;
      it.edge_valid = 1'b0;
      it.edge_from  = NODE_W'($urandom);
      it.edge_to    = NODE_W'($urandom);
      it.last_edge  = 1'b0;
      return it;
   endfunction

   function automatic void shuffle_graph();
      int j;
      ucd_pkg::req_type tmp;
      for (int i = graph_items.size() - 1; i > 0; i--) begin
         j              = $urandom_range(0, i);
         tmp            = graph_items[i];
         graph_items[i] = graph_items[j];
         graph_items[j] = tmp;
      end
   endfunction

   function automatic void compose_graph(shape_type shape);
      int span;
      int count;
      int base;
      int stride;
      int ids [16];
      ucd_pkg::req_type tmp;
      graph_items.delete();
      case ($urandom_range(0, 2))
         0: span = 16;
         1: span = 64;
         default: span = 256;
      endcase
      count  = $urandom_range(2, 12);
      base   = $urandom_range(0, span - 1);
      stride = (span == 256) ? 2 * $urandom_range(0, 127) + 1 : 1;
      for (int i = 0; i < count; i++) ids[i] = (base + i * stride) % 256;
      case (shape)
         SHAPE_TREE, SHAPE_LOOPED_TREE: begin
            for (int i = 1; i < count; i++)
               add_item(edge_item(ids[i], ids[$urandom_range(0, i - 1)]));
            // one extra edge on a tree always closes a loop (or is a self loop)
            if (shape == SHAPE_LOOPED_TREE)
               add_item(edge_item(ids[$urandom_range(0, count - 1)],
                                  ids[$urandom_range(0, count - 1)]));
         end
         SHAPE_SCATTER: begin
            for (int i = 0; i < count; i++)
               add_item(edge_item($urandom_range(0, span - 1),
                                  $urandom_range(0, span - 1)));
         end
         default: ;
      endcase
      shuffle_graph();
      if ($urandom_range(0, 5) == 0)
         graph_items.insert($urandom_range(0, graph_items.size()), noise_item());
      if (graph_items.size() == 0 || $urandom_range(0, 3) == 0)
         add_item(noise_item());
      tmp           = graph_items.pop_back();
      tmp.last_edge = 1'b1;
      add_item(tmp);
   endfunction

   // tree on 0..127, a ring on 128..255 and one parallel edge fill the store exactly, the rest is dropped
   function automatic void compose_crowded_graph();
      ucd_pkg::req_type tmp;
      graph_items.delete();
      for (int i = 1; i < 128; i++) add_item(edge_item(i, $urandom_range(0, i - 1)));
      for (int i = 128; i < 255; i++) add_item(edge_item(i, i + 1));
      add_item(edge_item(255, 128));
      add_item(edge_item(130, 131));
      shuffle_graph();
      add_item(edge_item(0, 0));
      add_item(edge_item(64, 64));
      add_item(edge_item(127, 1));
      tmp           = edge_item(5, 5);
      tmp.last_edge = 1'b1;
      add_item(tmp);
   endfunction

   function automatic logic [CFG_W-1:0] pick_root_count();
      case ($urandom_range(0, 7))
         0: return CFG_W'(1);
         1: return CFG_W'(0);
         2: return CFG_W'(511);
         3: return CFG_W'(256);
         4: return CFG_W'($urandom_range(2, 32));
         5: return CFG_W'($urandom_range(257, 511));
         default: return CFG_W'($urandom_range(1, 256));
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("[%0t] verdict %0d: %s", $time, verdicts_checked, what);
   endtask

   task automatic offer(ucd_pkg::req_type it, logic typed, ucd_pkg::rsp_type typed_verdict);
      ucd_pkg::rsp_type verdict;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (predict_verdict(it, verdict))
         pending_verdicts.insert(pending_verdicts.size(), typed ? typed_verdict : verdict);
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
      logic [DATA_W-1:0] wdata;
      logic [DATA_W-1:0] rdata;
      wait_for_verdicts();
      wdata              = $urandom;
      wdata[CFG_W-1:0]   = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == NODE_COUNT_ADDR) begin
         root_count = value;
         @(posedge clock);
         psel    <= 1'b1;
         pwrite  <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         rdata = prdata;
         psel    <= 1'b0;
         penable <= 1'b0;
         if (rdata[CFG_W-1:0] !== root_count)
            report_mismatch($sformatf("node_count reads %0d, written %0d",
                                      rdata[CFG_W-1:0], root_count));
      end
   endtask

   always @(posedge clock) begin : result_side
      ucd_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("result %b with no transaction pending", rsp_data));
            end else begin
               want = pending_verdicts.pop_front();
               verdicts_checked++;
               if (rsp_data.cycle_found !== want.cycle_found)
                  report_mismatch($sformatf("cycle_found %b, expected %b",
                                            rsp_data.cycle_found, want.cycle_found));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow %b, expected %b",
                                            rsp_data.overflow, want.overflow));
               cycles_reported += want.cycle_found;
               overflows_seen  += want.overflow;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
            $display("** undirected_cycle_detect_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      shape_type shape;
      bit        crowded_done;
      crowded_done = 1'b0;
      root_count   = ucd_pkg::NODE_COUNT_RESET;
      forget_graph();

      // empty graph, self loops at both ends of the id range, parallel edges
      add_row(mk_edge(0, 255, 255, 1, 1, 0, 0));
      add_row(mk_edge(1, 0, 0, 1, 1, 1, 0));
      add_row(mk_edge(1, 255, 255, 1, 1, 1, 0));
      add_row(mk_edge(1, 0, 255, 0, 0, 0, 0));
      add_row(mk_edge(1, 255, 0, 1, 1, 1, 0));
      // item with no edge and no end, then a plain path
      add_row(mk_edge(0, 170, 85, 0, 0, 0, 0));
      add_row(mk_edge(1, 1, 2, 0, 0, 0, 0));
      add_row(mk_edge(1, 2, 3, 0, 0, 0, 0));
      add_row(mk_edge(1, 3, 4, 1, 0, 0, 0));
      // triangle closed by an invalid last item
      add_row(mk_edge(1, 10, 11, 0, 0, 0, 0));
      add_row(mk_edge(1, 11, 12, 0, 0, 0, 0));
      add_row(mk_edge(1, 12, 10, 0, 0, 0, 0));
      add_row(mk_edge(0, 0, 0, 1, 1, 1, 0));
      // write to an unmapped index leaves 256 roots
      add_row(mk_csr(UNMAPPED_ADDR, 5));
      add_row(mk_edge(1, 200, 200, 1, 1, 1, 0));
      // loop not reachable from the single root
      add_row(mk_csr(NODE_COUNT_ADDR, 1));
      add_row(mk_edge(1, 5, 6, 0, 0, 0, 0));
      add_row(mk_edge(1, 6, 7, 0, 0, 0, 0));
      add_row(mk_edge(1, 7, 5, 1, 1, 0, 0));
      // zero roots, then a count above the node range saturates
      add_row(mk_csr(NODE_COUNT_ADDR, 0));
      add_row(mk_edge(1, 0, 0, 1, 1, 0, 0));
      add_row(mk_csr(NODE_COUNT_ADDR, 511));
      add_row(mk_edge(1, 255, 255, 1, 1, 1, 0));
      add_row(mk_csr(NODE_COUNT_ADDR, 256));
      add_row(mk_edge(1, 254, 253, 1, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) set_register(plan[i].addr, plan[i].value);
         else offer(plan[i].item, plan[i].typed, plan[i].verdict);
      end

      while (items_sent < RANDOM_TARGET) begin
         if (!crowded_done && items_sent >= CROWDED_AT) begin
            set_register(NODE_COUNT_ADDR, CFG_W'(128));
            compose_crowded_graph();
            crowded_done = 1'b1;
         end else begin
            if (graphs_sent % 6 == 0) set_register(NODE_COUNT_ADDR, pick_root_count());
            shape = shape_type'($urandom_range(0, 3));
            compose_graph(shape);
         end
         foreach (graph_items[i]) begin
            calm = (items_sent >= CALM_FROM);
            offer(graph_items[i], 1'b0, '0);
         end
         graphs_sent++;
      end

      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d graphs over %0d input transactions, %0d verdicts checked",
               graphs_sent, items_sent, verdicts_checked);
      $display("verdicts with a cycle: %0d, with dropped edges: %0d, mismatches: %0d",
               cycles_reported, overflows_seen, mismatches);
      if (mismatches == 0) begin
         $display("** undirected_cycle_detect_unit: PASSED **");
      end else begin
         $display("** undirected_cycle_detect_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ucd_pkg.sv
rtl/ucd_ram.sv
rtl/undirected_cycle_detect_unit.sv
sim/tb_undirected_cycle_detect_unit.sv
